[hw/rtl/lsrc_pkg.sv]
// Shared types and constants for the line segment rectangle clipper.
`timescale 1ns / 1ps
`default_nettype none
package lsrc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int REG_IDX_BITS   = 2;

  localparam int RST_LEFT   = 0;
  localparam int RST_RIGHT  = 499;
  localparam int RST_BOTTOM = 0;
  localparam int RST_TOP    = 499;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_e;

  // which boundary set a clipped endpoint
  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_X    = 2'd1,
    TAG_Y    = 2'd2
  } tag_e;

  // front end to clip stage
  typedef struct packed {
    logic direct;  // horizontal, vertical or empty rectangle: coords already final
    logic vis;     // visibility of a direct segment
    logic dy_neg;
  } seg_ctrl_t;

  // per endpoint fixup after the divider
  typedef struct packed {
    logic add_en;  // add the quotient to one coordinate
    logic add_y;   // 1: y gets the quotient, 0: x does
    logic neg;     // quotient sign
  } ep_ctrl_t;

  typedef struct packed {
    logic     vis;
    ep_ctrl_t ep0;
    ep_ctrl_t ep1;
  } div_ctrl_t;

endpackage
`default_nettype wire

[hw/rtl/lsrc_front.sv]
// Front stages: endpoint ordering, direct clamps, Liang-Barsky terms, cross products.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_front import lsrc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic signed [COORD_BITS-1:0]   left_i,
  input  logic signed [COORD_BITS-1:0]   right_i,
  input  logic signed [COORD_BITS-1:0]   bottom_i,
  input  logic signed [COORD_BITS-1:0]   top_i,
  input  logic signed [COORD_BITS-1:0]   start_x_i,
  input  logic signed [COORD_BITS-1:0]   start_y_i,
  input  logic signed [COORD_BITS-1:0]   end_x_i,
  input  logic signed [COORD_BITS-1:0]   end_y_i,
  output logic                           valid_o,
  output seg_ctrl_t                      ctrl_o,
  output logic signed [COORD_BITS-1:0]   x1_o,
  output logic signed [COORD_BITS-1:0]   y1_o,
  output logic signed [COORD_BITS-1:0]   x2_o,
  output logic signed [COORD_BITS-1:0]   y2_o,
  output logic signed [COORD_BITS-1:0]   left_o,
  output logic signed [COORD_BITS-1:0]   right_o,
  output logic signed [COORD_BITS-1:0]   yin_o,
  output logic signed [COORD_BITS-1:0]   yout_o,
  output logic signed [COORD_BITS:0]     dx_o,
  output logic signed [COORD_BITS:0]     ady_o,
  output logic signed [COORD_BITS:0]     nx0_o,
  output logic signed [COORD_BITS:0]     nx1_o,
  output logic signed [COORD_BITS:0]     ny0_o,
  output logic signed [COORD_BITS:0]     ny1_o,
  output logic signed [2*COORD_BITS+1:0] px0_o,
  output logic signed [2*COORD_BITS+1:0] px1_o,
  output logic signed [2*COORD_BITS+1:0] py0_o,
  output logic signed [2*COORD_BITS+1:0] py1_o
);

  localparam int W  = COORD_BITS;
  localparam int PW = 2*COORD_BITS+2;

  logic signed [W-1:0] lo_x, hi_x, lo_y, hi_y, ox1, oy1, ox2, oy2;
  logic signed [W-1:0] fx, fy, sx, sy, yin, yout;
  logic signed [W:0]   dx, dy, ady, ry0, ry1;
  logic                rect_ok, horiz, vert, swap, dvis, dy_pos;

  logic                v1_q, v2_q;
  seg_ctrl_t           c1_d, c1_q, c2_q;
  logic signed [W-1:0] x1_d, y1_d, x2_d, y2_d;
  logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q, l1_q, r1_q, yin1_q, yout1_q;
  logic signed [W:0]   dx_q, ady_q, nx0_d, nx1_d, ny0_d, ny1_d;
  logic signed [W:0]   nx0_q, nx1_q, ny0_q, ny1_q;

  always_comb begin
    rect_ok = (left_i <= right_i) && (bottom_i <= top_i);
    horiz   = start_y_i == end_y_i;
    vert    = start_x_i == end_x_i;
    swap    = start_x_i > end_x_i;
    lo_x    = swap ? end_x_i : start_x_i;
    hi_x    = swap ? start_x_i : end_x_i;
    ox1     = lo_x;
    ox2     = hi_x;
    oy1     = swap ? end_y_i : start_y_i;
    oy2     = swap ? start_y_i : end_y_i;
    hi_y    = (start_y_i < end_y_i) ? end_y_i : start_y_i;
    lo_y    = (start_y_i < end_y_i) ? start_y_i : end_y_i;

    // direct clamps for axis-parallel segments and points
    dvis = 1'b0;
    fx   = ox1;
    fy   = oy1;
    sx   = ox2;
    sy   = oy2;
    if (!rect_ok) begin
      dvis = 1'b0;
    end else if (horiz) begin
      dvis = !(start_y_i > top_i || start_y_i < bottom_i) &&
             !(hi_x < left_i) && !(lo_x > right_i);
      fx   = (lo_x < left_i) ? left_i : lo_x;
      fy   = start_y_i;
      sx   = (hi_x > right_i) ? right_i : hi_x;
      sy   = start_y_i;
    end else if (vert) begin
      dvis = !(start_x_i > right_i || start_x_i < left_i) &&
             !(hi_y < bottom_i) && !(lo_y > top_i);
      fx   = start_x_i;
      fy   = (hi_y > top_i) ? top_i : hi_y;
      sx   = start_x_i;
      sy   = (lo_y < bottom_i) ? bottom_i : lo_y;
    end

    c1_d.direct = !rect_ok || horiz || vert;
    c1_d.vis    = dvis;
    x1_d = fx;
    y1_d = fy;
    x2_d = sx;
    y2_d = sy;

    dx          = (W+1)'(ox2) - (W+1)'(ox1);
    dy          = (W+1)'(oy2) - (W+1)'(oy1);
    c1_d.dy_neg = dy[W];
    dy_pos      = !dy[W];
    ady         = dy[W] ? -dy : dy;
    yin         = dy_pos ? bottom_i : top_i;
    yout        = dy_pos ? top_i : bottom_i;
    nx0_d       = (W+1)'(left_i) - (W+1)'(ox1);
    nx1_d       = (W+1)'(right_i) - (W+1)'(ox1);
    ry0         = (W+1)'(yin) - (W+1)'(oy1);
    ry1         = (W+1)'(yout) - (W+1)'(oy1);
    ny0_d       = dy_pos ? ry0 : -ry0;
    ny1_d       = dy_pos ? ry1 : -ry1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q    <= c1_d;
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    x2_q    <= x2_d;
    y2_q    <= y2_d;
    l1_q    <= left_i;
    r1_q    <= right_i;
    yin1_q  <= yin;
    yout1_q <= yout;
    dx_q    <= dx;
    ady_q   <= ady;
    nx0_q   <= nx0_d;
    nx1_q   <= nx1_d;
    ny0_q   <= ny0_d;
    ny1_q   <= ny1_d;
  end

  // second stage: the four cross products
  always_ff @(posedge clk_i) begin
    c2_q    <= c1_q;
    x1_o    <= x1_q;
    y1_o    <= y1_q;
    x2_o    <= x2_q;
    y2_o    <= y2_q;
    left_o  <= l1_q;
    right_o <= r1_q;
    yin_o   <= yin1_q;
    yout_o  <= yout1_q;
    dx_o    <= dx_q;
    ady_o   <= ady_q;
    nx0_o   <= nx0_q;
    nx1_o   <= nx1_q;
    ny0_o   <= ny0_q;
    ny1_o   <= ny1_q;
    px0_o   <= PW'(nx0_q) * PW'(ady_q);
    px1_o   <= PW'(nx1_q) * PW'(ady_q);
    py0_o   <= PW'(ny0_q) * PW'(dx_q);
    py1_o   <= PW'(ny1_q) * PW'(dx_q);
  end

  assign valid_o = v2_q;
  assign ctrl_o  = c2_q;

endmodule
`default_nettype wire

[hw/rtl/lsrc_clip.sv]
// Clip stages: entry/exit boundary selection, visibility, divider operand setup.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_clip import lsrc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  seg_ctrl_t                      ctrl_i,
  input  logic signed [COORD_BITS-1:0]   x1_i,
  input  logic signed [COORD_BITS-1:0]   y1_i,
  input  logic signed [COORD_BITS-1:0]   x2_i,
  input  logic signed [COORD_BITS-1:0]   y2_i,
  input  logic signed [COORD_BITS-1:0]   left_i,
  input  logic signed [COORD_BITS-1:0]   right_i,
  input  logic signed [COORD_BITS-1:0]   yin_i,
  input  logic signed [COORD_BITS-1:0]   yout_i,
  input  logic signed [COORD_BITS:0]     dx_i,
  input  logic signed [COORD_BITS:0]     ady_i,
  input  logic signed [COORD_BITS:0]     nx0_i,
  input  logic signed [COORD_BITS:0]     nx1_i,
  input  logic signed [COORD_BITS:0]     ny0_i,
  input  logic signed [COORD_BITS:0]     ny1_i,
  input  logic signed [2*COORD_BITS+1:0] px0_i,
  input  logic signed [2*COORD_BITS+1:0] px1_i,
  input  logic signed [2*COORD_BITS+1:0] py0_i,
  input  logic signed [2*COORD_BITS+1:0] py1_i,
  output logic                           valid_o,
  output div_ctrl_t                      ctrl_o,
  output logic [2*COORD_BITS+1:0]        num0_o,
  output logic [COORD_BITS:0]            den0_o,
  output logic [2*COORD_BITS+1:0]        num1_o,
  output logic [COORD_BITS:0]            den1_o,
  output logic signed [COORD_BITS-1:0]   ep0_x_o,
  output logic signed [COORD_BITS-1:0]   ep0_y_o,
  output logic signed [COORD_BITS-1:0]   ep1_x_o,
  output logic signed [COORD_BITS-1:0]   ep1_y_o
);

  localparam int W  = COORD_BITS;
  localparam int PW = 2*COORD_BITS+2;

  tag_e                 tag0, tag1, tag0_q, tag1_q;
  logic                 empty, vis3;
  logic                 v3_q, v4_q, vis_q, direct_q;
  logic                 negx0_q, negy0_q, negx1_q, negy1_q;
  logic signed [W-1:0]  x1_q, y1_q, x2_q, y2_q, l_q, r_q, yin_q, yout_q;
  logic signed [W:0]    dx_q, ady_q;
  logic signed [PW-1:0] px0_q, px1_q, py0_q, py1_q, p0, p1;
  logic [W:0]           den0, den1;
  div_ctrl_t            dc;
  logic signed [W-1:0]  e0x, e0y, e1x, e1y;

  // Liang-Barsky interval: t0 = max(0, tx0, ty0), t1 = min(1, tx1, ty1)
  always_comb begin
    tag0 = (nx0_i > 0) ? TAG_X : TAG_NONE;
    if ((tag0 == TAG_X) ? (py0_i > px0_i) : (ny0_i > 0)) tag0 = TAG_Y;
    tag1 = (nx1_i < dx_i) ? TAG_X : TAG_NONE;
    if ((tag1 == TAG_X) ? (py1_i < px1_i) : (ny1_i < ady_i)) tag1 = TAG_Y;

    empty = 1'b0;
    case (tag0)
      TAG_X: begin
        case (tag1)
          TAG_X:   empty = nx0_i > nx1_i;
          TAG_Y:   empty = px0_i > py1_i;
          default: empty = nx0_i > dx_i;
        endcase
      end
      TAG_Y: begin
        case (tag1)
          TAG_X:   empty = py0_i > px1_i;
          TAG_Y:   empty = ny0_i > ny1_i;
          default: empty = ny0_i > ady_i;
        endcase
      end
      default: begin
        case (tag1)
          TAG_X:   empty = nx1_i < 0;
          TAG_Y:   empty = ny1_i < 0;
          default: empty = 1'b0;
        endcase
      end
    endcase
    vis3 = ctrl_i.direct ? ctrl_i.vis : !empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag0_q   <= tag0;
    tag1_q   <= tag1;
    vis_q    <= vis3;
    direct_q <= ctrl_i.direct;
    negx0_q  <= ctrl_i.dy_neg ^ nx0_i[W];
    negy0_q  <= ny0_i[W];
    negx1_q  <= ctrl_i.dy_neg ^ nx1_i[W];
    negy1_q  <= ny1_i[W];
    x1_q     <= x1_i;
    y1_q     <= y1_i;
    x2_q     <= x2_i;
    y2_q     <= y2_i;
    l_q      <= left_i;
    r_q      <= right_i;
    yin_q    <= yin_i;
    yout_q   <= yout_i;
    dx_q     <= dx_i;
    ady_q    <= ady_i;
    px0_q    <= px0_i;
    px1_q    <= px1_i;
    py0_q    <= py0_i;
    py1_q    <= py1_i;
  end

  // operand setup: endpoint = fixed boundary plus rounded offset
  always_comb begin
    dc.vis = vis_q;
    p0     = px0_q;
    den0   = dx_q;
    e0x    = x1_q;
    e0y    = y1_q;
    dc.ep0 = '{add_en: 1'b0, add_y: 1'b0, neg: 1'b0};
    p1     = px1_q;
    den1   = dx_q;
    e1x    = x2_q;
    e1y    = y2_q;
    dc.ep1 = '{add_en: 1'b0, add_y: 1'b0, neg: 1'b0};
    if (!direct_q) begin
      case (tag0_q)
        TAG_X: begin
          e0x    = l_q;
          dc.ep0 = '{add_en: 1'b1, add_y: 1'b1, neg: negx0_q};
        end
        TAG_Y: begin
          p0     = py0_q;
          den0   = ady_q;
          e0y    = yin_q;
          dc.ep0 = '{add_en: 1'b1, add_y: 1'b0, neg: negy0_q};
        end
        default: ;
      endcase
      case (tag1_q)
        TAG_X: begin
          e1x    = r_q;
          e1y    = y1_q;
          dc.ep1 = '{add_en: 1'b1, add_y: 1'b1, neg: negx1_q};
        end
        TAG_Y: begin
          p1     = py1_q;
          den1   = ady_q;
          e1x    = x1_q;
          e1y    = yout_q;
          dc.ep1 = '{add_en: 1'b1, add_y: 1'b0, neg: negy1_q};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_o  <= dc;
    num0_o  <= p0[PW-1] ? PW'(-p0) : PW'(p0);
    num1_o  <= p1[PW-1] ? PW'(-p1) : PW'(p1);
    den0_o  <= den0;
    den1_o  <= den1;
    ep0_x_o <= e0x;
    ep0_y_o <= e0y;
    ep1_x_o <= e1x;
    ep1_y_o <= e1y;
  end

  assign valid_o = v4_q;

endmodule
`default_nettype wire

[hw/rtl/lsrc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, rounds half away from zero.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_div import lsrc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [2*COORD_BITS+1:0] num_i,
  input  logic [COORD_BITS:0]     den_i,
  output logic [COORD_BITS-1:0]   quo_o
);

  localparam int W = COORD_BITS;

  logic [W+1:0] r_q [W];
  logic [W-1:0] q_q [W];
  logic [W-1:0] m_q [W];
  logic [W:0]   d_q [W];
  logic [W+2:0] half;
  logic         rnd;

  // quotient is known to fit W bits, so the top part of num starts as remainder
  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W+1:0] r_in;
    logic [W-1:0] q_in, m_in;
    logic [W:0]   d_in;
    logic [W+2:0] trial, diff;
    logic         ge;
    if (i == 0) begin : g_first
      assign r_in = num_i[2*W+1:W];
      assign q_in = '0;
      assign m_in = num_i[W-1:0];
      assign d_in = den_i;
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign q_in = q_q[i-1];
      assign m_in = m_q[i-1];
      assign d_in = d_q[i-1];
    end
    assign trial = {r_in, m_in[W-1-i]};
    assign ge    = trial >= (W+3)'(d_in);
    assign diff  = trial - (W+3)'(d_in);
    always_ff @(posedge clk_i) begin
      r_q[i] <= ge ? diff[W+1:0] : trial[W+1:0];
      q_q[i] <= {q_in[W-2:0], ge};
      m_q[i] <= m_in;
      d_q[i] <= d_in;
    end
  end

  assign half  = {r_q[W-1], 1'b0};
  assign rnd   = half >= (W+3)'(d_q[W-1]);
  assign quo_o = q_q[W-1] + W'(rnd);

endmodule
`default_nettype wire

[hw/rtl/line_segment_rect_clipper_top.sv]
// Pipeline: a segment accepted at a clock edge passes four setup stages, one divider stage per
// quotient bit and one output stage before its result shows.
// Throughput: one segment per cycle, fixed by the pipelined dividers; busy stays low.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
// Reset clears the valid bits and loads the bounds 0, 499, 0, 499.
`timescale 1ns / 1ps
`default_nettype none
module line_segment_rect_clipper_top import lsrc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  logic                          cfg_we_i,
  input  logic [REG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [COORD_BITS-1:0]         cfg_data_i,
  output logic                          done_o,
  output logic                          visible_o,
  output logic signed [COORD_BITS-1:0]  first_x_o,
  output logic signed [COORD_BITS-1:0]  first_y_o,
  output logic signed [COORD_BITS-1:0]  second_x_o,
  output logic signed [COORD_BITS-1:0]  second_y_o
);

  localparam int W = COORD_BITS;

  logic signed [W-1:0]   left_q, right_q, bottom_q, top_q;

  logic                  f_valid;
  seg_ctrl_t             f_ctrl;
  logic signed [W-1:0]   f_x1, f_y1, f_x2, f_y2, f_l, f_r, f_yin, f_yout;
  logic signed [W:0]     f_dx, f_ady, f_nx0, f_nx1, f_ny0, f_ny1;
  logic signed [2*W+1:0] f_px0, f_px1, f_py0, f_py1;

  logic                  c_valid;
  div_ctrl_t             c_ctrl;
  logic [2*W+1:0]        c_num0, c_num1;
  logic [W:0]            c_den0, c_den1;
  logic signed [W-1:0]   c_e0x, c_e0y, c_e1x, c_e1y;

  logic [W-1:0]          quo0, quo1, sq0, sq1;

  logic                  sv_q [W];
  div_ctrl_t             sc_q [W];
  logic signed [W-1:0]   s0x_q [W], s0y_q [W], s1x_q [W], s1y_q [W];

  div_ctrl_t             lc;
  logic signed [W-1:0]   fx, fy, sx, sy;
  logic                  done_q, vis_q;
  logic signed [W-1:0]   fx_q, fy_q, sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= W'(RST_LEFT);
      right_q  <= W'(RST_RIGHT);
      bottom_q <= W'(RST_BOTTOM);
      top_q    <= W'(RST_TOP);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  lsrc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .left_i     (left_q),
    .right_i    (right_q),
    .bottom_i   (bottom_q),
    .top_i      (top_q),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .valid_o    (f_valid),
    .ctrl_o     (f_ctrl),
    .x1_o       (f_x1),
    .y1_o       (f_y1),
    .x2_o       (f_x2),
    .y2_o       (f_y2),
    .left_o     (f_l),
    .right_o    (f_r),
    .yin_o      (f_yin),
    .yout_o     (f_yout),
    .dx_o       (f_dx),
    .ady_o      (f_ady),
    .nx0_o      (f_nx0),
    .nx1_o      (f_nx1),
    .ny0_o      (f_ny0),
    .ny1_o      (f_ny1),
    .px0_o      (f_px0),
    .px1_o      (f_px1),
    .py0_o      (f_py0),
    .py1_o      (f_py1)
  );

  lsrc_clip #(.COORD_BITS(COORD_BITS)) u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ctrl_i  (f_ctrl),
    .x1_i    (f_x1),
    .y1_i    (f_y1),
    .x2_i    (f_x2),
    .y2_i    (f_y2),
    .left_i  (f_l),
    .right_i (f_r),
    .yin_i   (f_yin),
    .yout_i  (f_yout),
    .dx_i    (f_dx),
    .ady_i   (f_ady),
    .nx0_i   (f_nx0),
    .nx1_i   (f_nx1),
    .ny0_i   (f_ny0),
    .ny1_i   (f_ny1),
    .px0_i   (f_px0),
    .px1_i   (f_px1),
    .py0_i   (f_py0),
    .py1_i   (f_py1),
    .valid_o (c_valid),
    .ctrl_o  (c_ctrl),
    .num0_o  (c_num0),
    .den0_o  (c_den0),
    .num1_o  (c_num1),
    .den1_o  (c_den1),
    .ep0_x_o (c_e0x),
    .ep0_y_o (c_e0y),
    .ep1_x_o (c_e1x),
    .ep1_y_o (c_e1y)
  );

  lsrc_div #(.COORD_BITS(COORD_BITS)) u_div0 (
    .clk_i (clk_i),
    .num_i (c_num0),
    .den_i (c_den0),
    .quo_o (quo0)
  );

  lsrc_div #(.COORD_BITS(COORD_BITS)) u_div1 (
    .clk_i (clk_i),
    .num_i (c_num1),
    .den_i (c_den1),
    .quo_o (quo1)
  );

  // sideband that travels alongside the divider stages
  for (genvar i = 0; i < W; i++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i] <= 1'b0;
      end else begin
        sv_q[i] <= (i == 0) ? c_valid : sv_q[(i == 0) ? 0 : i-1];
      end
    end
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        sc_q[i]  <= c_ctrl;
        s0x_q[i] <= c_e0x;
        s0y_q[i] <= c_e0y;
        s1x_q[i] <= c_e1x;
        s1y_q[i] <= c_e1y;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        sc_q[i]  <= sc_q[i-1];
        s0x_q[i] <= s0x_q[i-1];
        s0y_q[i] <= s0y_q[i-1];
        s1x_q[i] <= s1x_q[i-1];
        s1y_q[i] <= s1y_q[i-1];
      end
    end
  end

  always_comb begin
    lc  = sc_q[W-1];
    sq0 = lc.ep0.neg ? W'(-quo0) : quo0;
    sq1 = lc.ep1.neg ? W'(-quo1) : quo1;
    fx  = s0x_q[W-1];
    fy  = s0y_q[W-1];
    sx  = s1x_q[W-1];
    sy  = s1y_q[W-1];
    if (lc.ep0.add_en) begin
      if (lc.ep0.add_y) fy = fy + $signed(sq0);
      else              fx = fx + $signed(sq0);
    end
    if (lc.ep1.add_en) begin
      if (lc.ep1.add_y) sy = sy + $signed(sq1);
      else              sx = sx + $signed(sq1);
    end
    if (!lc.vis) begin
      fx = '0;
      fy = '0;
      sx = '0;
      sy = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sv_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    vis_q <= lc.vis;
    fx_q  <= fx;
    fy_q  <= fy;
    sx_q  <= sx;
    sy_q  <= sy;
  end

  assign done_o     = done_q;
  assign visible_o  = vis_q;
  assign first_x_o  = fx_q;
  assign first_y_o  = fy_q;
  assign second_x_o = sx_q;
  assign second_y_o = sy_q;

endmodule
`default_nettype wire

[hw/rtl/lsrc_chk.sv]
// Port-level checker for the clipper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_chk import lsrc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic                         visible_o,
  input logic signed [COORD_BITS-1:0] first_x_o,
  input logic signed [COORD_BITS-1:0] first_y_o,
  input logic signed [COORD_BITS-1:0] second_x_o,
  input logic signed [COORD_BITS-1:0] second_y_o
);

  localparam int LAT = COORD_BITS + 5;

  // every accepted word produces a result on done_o
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("result missing after accepted word");

  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without matching accepted word");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !visible_o) |->
      (first_x_o == 0 && first_y_o == 0 && second_x_o == 0 && second_y_o == 0))
    else $error("rejected segment with nonzero coordinates");

  a_x_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && visible_o) |-> (first_x_o <= second_x_o))
    else $error("clipped endpoints out of x order");

endmodule

bind line_segment_rect_clipper_top lsrc_chk #(.COORD_BITS(COORD_BITS)) u_lsrc_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .visible_o  (visible_o),
  .first_x_o  (first_x_o),
  .first_y_o  (first_y_o),
  .second_x_o (second_x_o),
  .second_y_o (second_y_o)
);
`default_nettype wire

[verif/lsrc_checker.sv]
// Checker for the line segment clipper: predicts each clipped segment and compares results.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_checker import lsrc_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [COORD_BITS_DEF-1:0]  start_x_i,
  input  logic signed [COORD_BITS_DEF-1:0]  start_y_i,
  input  logic signed [COORD_BITS_DEF-1:0]  end_x_i,
  input  logic signed [COORD_BITS_DEF-1:0]  end_y_i,
  input  logic                              cfg_we_i,
  input  logic [REG_IDX_BITS-1:0]           cfg_idx_i,
  input  logic [COORD_BITS_DEF-1:0]         cfg_data_i,
  input  logic                              done_o,
  input  logic                              visible_o,
  input  logic signed [COORD_BITS_DEF-1:0]  first_x_o,
  input  logic signed [COORD_BITS_DEF-1:0]  first_y_o,
  input  logic signed [COORD_BITS_DEF-1:0]  second_x_o,
  input  logic signed [COORD_BITS_DEF-1:0]  second_y_o,
  output int                                errors_o,
  output int                                pending_o,
  output int                                n_seg_o,
  output int                                n_vis_o
);

  typedef struct packed {
    logic                             vis;
    logic signed [COORD_BITS_DEF-1:0] fx;
    logic signed [COORD_BITS_DEF-1:0] fy;
    logic signed [COORD_BITS_DEF-1:0] sx;
    logic signed [COORD_BITS_DEF-1:0] sy;
  } clip_t;

  clip_t clipped_q[$];
  logic signed [COORD_BITS_DEF-1:0] lb, rb, bb, tb_r;

  // sign of a/b - c/d with b, d > 0; products fit easily in 64 bits
  function automatic int frac_cmp(longint a, longint b, longint c, longint d);
    longint p;
    p = a * d - c * b;
    return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
  endfunction

  // round(a*b/den), half away from zero
  function automatic longint round_div(longint a, longint b, longint den);
    longint prod, m, q, r;
    if (den < 0) begin
      den = -den;
      b = -b;
    end
    prod = a * b;
    m = (prod < 0) ? -prod : prod;
    q = m / den;
    r = m % den;
    if (2 * r >= den) q++;
    return (prod < 0) ? -q : q;
  endfunction

  function automatic clip_t clip_segment(longint x1, longint y1, longint x2, longint y2);
    longint lo_x, hi_x, lo_y, hi_y, t, fx, fy, sx, sy;
    longint dx, dy, ady, yin, yout, sg, n0, d0, n1, d1;
    tag_e tag0, tag1;
    logic vis;
    clip_t res;
    lo_x = lb; hi_x = rb; lo_y = bb; hi_y = tb_r;
    vis = (lo_x <= hi_x) && (lo_y <= hi_y);
    fx = 0; fy = 0; sx = 0; sy = 0;
    if (vis && y1 == y2) begin
      if (y1 > hi_y || y1 < lo_y) vis = 0;
      else begin
        if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
        if ((x2 < lo_x) || (x1 > hi_x)) vis = 0;
        else begin
          if (x1 < lo_x) x1 = lo_x;
          if (x2 > hi_x) x2 = hi_x;
        end
      end
      fx = x1; fy = y1; sx = x2; sy = y2;
    end else if (vis && x1 == x2) begin
      if (x1 > hi_x || x1 < lo_x) vis = 0;
      else begin
        if (y1 < y2) begin t = y1; y1 = y2; y2 = t; end
        if ((y1 < lo_y) || (y2 > hi_y)) vis = 0;
        else begin
          if (y1 > hi_y) y1 = hi_y;
          if (y2 < lo_y) y2 = lo_y;
        end
      end
      fx = x1; fy = y1; sx = x2; sy = y2;
    end else if (vis) begin
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      sg = (dy > 0) ? 1 : -1;
      ady = dy * sg;
      yin = (dy > 0) ? lo_y : hi_y;
      yout = (dy > 0) ? hi_y : lo_y;
      n0 = 0; d0 = 1; n1 = 1; d1 = 1;
      tag0 = TAG_NONE; tag1 = TAG_NONE;
      fx = x1; fy = y1; sx = x2; sy = y2;
      // entry parameter is the largest lower bound, exit the smallest upper bound
      if (frac_cmp(lo_x - x1, dx, n0, d0) > 0) begin
        n0 = lo_x - x1; d0 = dx; tag0 = TAG_X;
      end
      if (frac_cmp((yin - y1) * sg, ady, n0, d0) > 0) begin
        n0 = (yin - y1) * sg; d0 = ady; tag0 = TAG_Y;
      end
      if (frac_cmp(hi_x - x1, dx, n1, d1) < 0) begin
        n1 = hi_x - x1; d1 = dx; tag1 = TAG_X;
      end
      if (frac_cmp((yout - y1) * sg, ady, n1, d1) < 0) begin
        n1 = (yout - y1) * sg; d1 = ady; tag1 = TAG_Y;
      end
      if (frac_cmp(n0, d0, n1, d1) > 0) vis = 0;
      else begin
        if (tag0 == TAG_X) begin
          fx = lo_x; fy = y1 + round_div(dy, lo_x - x1, dx);
        end else if (tag0 == TAG_Y) begin
          fy = yin; fx = x1 + round_div(dx, yin - y1, dy);
        end
        if (tag1 == TAG_X) begin
          sx = hi_x; sy = y1 + round_div(dy, hi_x - x1, dx);
        end else if (tag1 == TAG_Y) begin
          sy = yout; sx = x1 + round_div(dx, yout - y1, dy);
        end
      end
    end
    if (!vis) begin
      fx = 0; fy = 0; sx = 0; sy = 0;
    end
    res.vis = vis;
    res.fx = fx[COORD_BITS_DEF-1:0];
    res.fy = fy[COORD_BITS_DEF-1:0];
    res.sx = sx[COORD_BITS_DEF-1:0];
    res.sy = sy[COORD_BITS_DEF-1:0];
    return res;
  endfunction

  assign pending_o = clipped_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    clip_t exp_c;
    if (!rst_ni) begin
      lb <= COORD_BITS_DEF'(RST_LEFT);
      rb <= COORD_BITS_DEF'(RST_RIGHT);
      bb <= COORD_BITS_DEF'(RST_BOTTOM);
      tb_r <= COORD_BITS_DEF'(RST_TOP);
      clipped_q.delete();
      errors_o <= 0;
      n_seg_o <= 0;
      n_vis_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_LEFT:   lb <= cfg_data_i;
          REG_RIGHT:  rb <= cfg_data_i;
          REG_BOTTOM: bb <= cfg_data_i;
          REG_TOP:    tb_r <= cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        clipped_q.push_back(clip_segment(start_x_i, start_y_i, end_x_i, end_y_i));
        n_seg_o <= n_seg_o + 1;
      end
      if (done_o) begin
        if (clipped_q.size() == 0) begin
          $display("%0t: unexpected result word vis=%0b (%0d,%0d)-(%0d,%0d)", $time,
                   visible_o, first_x_o, first_y_o, second_x_o, second_y_o);
          errors_o <= errors_o + 1;
        end else begin
          exp_c = clipped_q.pop_front();
          if (exp_c.vis) n_vis_o <= n_vis_o + 1;
          if (exp_c.vis !== visible_o || exp_c.fx !== first_x_o || exp_c.fy !== first_y_o ||
              exp_c.sx !== second_x_o || exp_c.sy !== second_y_o) begin
            $display("%0t: mismatch expected vis=%0b (%0d,%0d)-(%0d,%0d)", $time,
                     exp_c.vis, exp_c.fx, exp_c.fy, exp_c.sx, exp_c.sy);
            $display("%0t:          actual   vis=%0b (%0d,%0d)-(%0d,%0d)", $time,
                     visible_o, first_x_o, first_y_o, second_x_o, second_y_o);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[verif/tb.sv]
// Top of the clipper testbench: clock, reset, bound settings and segment stimulus.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import lsrc_pkg::*;

  localparam int W = COORD_BITS_DEF;
  localparam int LATENCY = W + 5;
  localparam int IDLE_LIMIT = 1000;

  logic clk_i, rst_ni, start, busy, cfg_we_i, done_o, visible_o;
  logic signed [W-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic signed [W-1:0] first_x_o, first_y_o, second_x_o, second_y_o;
  logic [REG_IDX_BITS-1:0] cfg_idx_i;
  logic [W-1:0] cfg_data_i;
  int errors, pending, n_seg, n_vis, idle_cycles;
  int bl, br, bbt, btp;

  line_segment_rect_clipper_top u_dut (.*);

  lsrc_checker u_chk (
    .clk_i, .rst_ni, .start, .busy, .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o, .visible_o, .first_x_o, .first_y_o,
    .second_x_o, .second_y_o, .errors_o(errors), .pending_o(pending),
    .n_seg_o(n_seg), .n_vis_o(n_vis)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: cycles in which no segment or result word moves
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_seg(int ax, int ay, int bx, int by);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    start_x_i <= W'(ax);
    start_y_i <= W'(ay);
    end_x_i <= W'(bx);
    end_y_i <= W'(by);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_bounds(int l, int r, int b, int t);
    reg_idx_e idx;
    int vals[4];
    vals = '{l, r, b, t};
    for (int i = 0; i < 4; i++) begin
      idx = reg_idx_e'(i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= W'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    bl = l; br = r; bbt = b; btp = t;
  endtask

  function automatic int near_coord(int lo, int hi);
    int a, b, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    v = a - 64 + int'($urandom_range(0, b - a + 128));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($signed(W'($urandom)));
  endfunction

  task automatic random_segs(int count);
    int ax, ay, bx, by;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ax = near_coord(bl, br); ay = near_coord(bbt, btp);
          bx = near_coord(bl, br); by = near_coord(bbt, btp);
        end
        4: begin
          ax = near_coord(bl, br); ay = near_coord(bbt, btp);
          bx = near_coord(bl, br); by = ay;
        end
        5: begin
          ax = near_coord(bl, br); ay = near_coord(bbt, btp);
          bx = ax; by = near_coord(bbt, btp);
        end
        6: begin
          ax = near_coord(bl, br); ay = near_coord(bbt, btp);
          bx = ax; by = ay;
        end
        default: begin
          ax = rand_coord(); ay = rand_coord();
          bx = rand_coord(); by = rand_coord();
        end
      endcase
      send_seg(ax, ay, bx, by);
    end
  endtask

  initial begin
    int rl, rr, rb, rt;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    start_x_i = '0; start_y_i = '0; end_x_i = '0; end_y_i = '0;
    idle_cycles = 0;
    bl = RST_LEFT; br = RST_RIGHT; bbt = RST_BOTTOM; btp = RST_TOP;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed segments against the reset rectangle 0..499
    send_seg(10, 20, 300, 20);
    send_seg(600, 100, -100, 100);
    send_seg(-50, 600, -10, 600);
    send_seg(100, -100, 100, 700);
    send_seg(100, 700, 100, -100);
    send_seg(250, 250, 250, 250);
    send_seg(600, 600, 600, 600);
    send_seg(-100, -100, 600, 600);   // both corners
    send_seg(-1, 1, 1, -1);           // grazes the origin corner
    send_seg(400, 600, 600, 400);     // misses outside the top right
    send_seg(-32768, -32768, 32767, 32767);
    send_seg(32767, -32768, -32768, 32767);
    send_seg(-32768, 0, 32767, 1);
    send_seg(0, -32768, 1, 32767);
    send_seg(0, 10, 10, 0);
    send_seg(-10, 250, 510, 260);
    send_seg(-32768, -32768, -32768, -32768);
    send_seg(32767, 32767, 32767, 32767);
    send_seg(499, 0, 499, 499);
    send_seg(3, 7, 998, 500);         // rounding near half steps
    random_segs(110);
    drain();

    set_bounds(-32768, 32767, -32768, 32767);
    random_segs(110);
    drain();
    set_bounds(-20, 20, -5, 5);
    random_segs(110);
    drain();
    set_bounds(100, 50, 0, 499);      // empty in x
    random_segs(60);
    drain();
    set_bounds(0, 499, 300, 200);     // empty in y
    random_segs(60);
    drain();
    set_bounds(7, 7, -3, -3);         // rectangle is a single point
    random_segs(80);
    drain();
    for (int k = 0; k < 3; k++) begin
      rl = rand_coord(); rr = rand_coord(); rb = rand_coord(); rt = rand_coord();
      if (rl > rr) begin int s; s = rl; rl = rr; rr = s; end
      if (rb > rt) begin int s; s = rb; rb = rt; rt = s; end
      set_bounds(rl, rr, rb, rt);
      random_segs(75);
      drain();
    end

    $display("Clipped %0d segments (%0d visible) over nine rectangles incl. empty,", n_seg,
             n_vis);
    $display("point-sized and full-range bounds, with random sender gaps.");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
